@@ src/compass_heading_smoother_core_defines.svh @@
// Assertion macros used by the checker file of the heading smoother.
`ifndef COMPASS_HEADING_SMOOTHER_CORE_DEFINES_SVH
`define COMPASS_HEADING_SMOOTHER_CORE_DEFINES_SVH

// Checks the consequent in the cycle after the antecedent, ignored while in reset.
`define CHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checks the consequent in the same cycle as the antecedent, reset included.
`define CHS_ASSERT_NOW(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/chs_pkg.sv @@
package chs_pkg;

   localparam int CHS_ANGLE_BITS   = 16;
   localparam int CHS_CORDIC_STEPS = 16;
   localparam int CHS_TABLE_LEN    = 24;
   localparam int CHS_IDX_W        = 5;
   localparam int CHS_PRESCALE     = 20;
   localparam int CHS_QUEUE_DEPTH  = 2;
   localparam int CHS_SAMPLE_W     = 16;
   localparam int CHS_OUT_W        = 16;
   localparam int CHS_ALPHA_W      = 9;
   localparam int CHS_ACC_W        = 32;

   localparam logic [CHS_ALPHA_W-1:0] CHS_ALPHA_RESET = 9'd51;
   localparam logic [CHS_ALPHA_W-1:0] CHS_ALPHA_ONE   = 9'd256;

   // One classified sample: the vector is already turned into the right half plane.
   typedef struct packed {
      logic                           zero;
      logic                           flip;
      logic signed [CHS_SAMPLE_W:0]   x;
      logic signed [CHS_SAMPLE_W:0]   y;
   } chs_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } chs_qstat_type;

   // Arctangent of 2^-i, with a full turn as 2^32.
   function automatic logic [CHS_ACC_W-1:0] chs_atan(input logic [CHS_IDX_W-1:0] idx);
      logic [CHS_ACC_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ src/chs_front.sv @@
module chs_front
   import chs_pkg::*;
(
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,
   input  chs_qstat_type q_status,
   output logic          push,
   output chs_entry_type push_entry
);

   logic signed [CHS_SAMPLE_W-1:0] mag_x;
   logic signed [CHS_SAMPLE_W-1:0] mag_y;
   logic signed [CHS_SAMPLE_W:0]   x_ext;
   logic signed [CHS_SAMPLE_W:0]   y_ext;

   always_comb begin
      mag_x = $signed(req_tdata[CHS_SAMPLE_W-1:0]);
      mag_y = $signed(req_tdata[2*CHS_SAMPLE_W-1:CHS_SAMPLE_W]);
      x_ext = (CHS_SAMPLE_W+1)'(mag_x);
      y_ext = (CHS_SAMPLE_W+1)'(mag_y);
      push_entry.zero = (mag_x == '0) && (mag_y == '0);
      // A vector in the left half plane is turned by half a turn before the CORDIC.
      push_entry.flip = mag_x[CHS_SAMPLE_W-1];
      push_entry.x    = push_entry.flip ? -x_ext : x_ext;
      push_entry.y    = push_entry.flip ? -y_ext : y_ext;
   end

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && !q_status.full;

endmodule

@@ src/chs_queue.sv @@
module chs_queue
   import chs_pkg::*;
#(
   parameter int DEPTH = CHS_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  chs_entry_type push_entry,
   input  logic          pop,
   output chs_entry_type pop_entry,
   output chs_qstat_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   chs_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry    = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

@@ src/chs_back.sv @@
module chs_back
   import chs_pkg::*;
#(
   parameter int ANGLE_BITS   = CHS_ANGLE_BITS,
   parameter int CORDIC_STEPS = CHS_CORDIC_STEPS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  chs_qstat_type          q_status,
   input  chs_entry_type          q_entry,
   output logic                   pop,
   input  logic [CHS_ALPHA_W-1:0] alpha,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata
);

   localparam int XY_W      = CHS_SAMPLE_W + CHS_PRESCALE + 4;
   localparam int DW        = ANGLE_BITS + 2;
   localparam int PW        = DW + CHS_ALPHA_W + 1;
   localparam int STEPS_EFF = (CORDIC_STEPS > CHS_TABLE_LEN) ? CHS_TABLE_LEN : CORDIC_STEPS;
   localparam logic [CHS_IDX_W-1:0] LAST_IDX = CHS_IDX_W'(STEPS_EFF - 1);
   localparam logic [CHS_ACC_W-1:0] ROUND_Z  = CHS_ACC_W'(1) << (31 - ANGLE_BITS);
   localparam logic [CHS_ACC_W-1:0] HALF_Z   = CHS_ACC_W'(1) << (CHS_ACC_W - 1);
   localparam logic signed [DW-1:0] HALF_D   = DW'(1) << (ANGLE_BITS - 1);
   localparam logic signed [DW-1:0] TURN_D   = DW'(1) << ANGLE_BITS;
   localparam logic signed [PW-1:0] ROUND_P  = PW'(128);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ITER = 3'd1;
   localparam logic [2:0] ST_RAW  = 3'd2;
   localparam logic [2:0] ST_DIFF = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [CHS_IDX_W-1:0]        iter_ff, iter_in;
   logic signed [XY_W-1:0]      x_ff, x_in;
   logic signed [XY_W-1:0]      y_ff, y_in;
   logic [CHS_ACC_W-1:0]        z_ff, z_in;
   logic                        zero_ff, zero_in;
   logic [ANGLE_BITS-1:0]       raw_ff, raw_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic [ANGLE_BITS-1:0]       held_ff, held_in;
   logic                        first_ff, first_in;
   logic                        out_valid_ff, out_valid_in;
   logic [CHS_OUT_W-1:0]        out_smooth_ff, out_smooth_in;
   logic [CHS_OUT_W-1:0]        out_raw_ff, out_raw_in;

   logic signed [XY_W-1:0]      xs;
   logic signed [XY_W-1:0]      ys;
   logic [CHS_ACC_W-1:0]        z_round;
   logic signed [DW-1:0]        d_raw;
   logic signed [DW-1:0]        d_wrap;
   logic [CHS_ALPHA_W-1:0]      alpha_sat;
   logic signed [PW-1:0]        p_round;
   logic signed [PW-1:0]        step_v;
   logic signed [ANGLE_BITS-1:0] new_held;
   logic signed [ANGLE_BITS-1:0] raw_s;
   logic signed [31:0]          held_ext;
   logic signed [31:0]          raw_ext;
   logic                        emit;

   always_comb begin
      state_in      = state_ff;
      iter_in       = iter_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      zero_in       = zero_ff;
      raw_in        = raw_ff;
      prod_in       = prod_ff;
      held_in       = held_ff;
      first_in      = first_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_smooth_in = out_smooth_ff;
      out_raw_in    = out_raw_ff;
      pop           = 1'b0;
      emit          = 1'b0;

      xs      = x_ff >>> iter_ff;
      ys      = y_ff >>> iter_ff;
      z_round = z_ff + ROUND_Z;

      // Difference to the held heading, folded into the shortest way round.
      d_raw  = DW'($signed(raw_ff)) - DW'($signed(held_ff));
      d_wrap = d_raw;
      if (d_raw > HALF_D) begin
         d_wrap = d_raw - TURN_D;
      end else if (d_raw < -HALF_D) begin
         d_wrap = d_raw + TURN_D;
      end
      alpha_sat = (alpha > CHS_ALPHA_ONE) ? CHS_ALPHA_ONE : alpha;

      p_round  = prod_ff + ROUND_P;
      step_v   = p_round >>> 8;
      new_held = first_ff ? $signed(raw_ff)
                          : $signed(held_ff + step_v[ANGLE_BITS-1:0]);
      raw_s    = $signed(raw_ff);
      held_ext = 32'(new_held);
      raw_ext  = 32'(raw_s);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop     = 1'b1;
               x_in    = XY_W'($signed(q_entry.x)) <<< CHS_PRESCALE;
               y_in    = XY_W'($signed(q_entry.y)) <<< CHS_PRESCALE;
               z_in    = q_entry.flip ? HALF_Z : '0;
               zero_in = q_entry.zero;
               iter_in = '0;
               state_in = q_entry.zero ? ST_RAW : ST_ITER;
            end
         end
         ST_ITER: begin
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + chs_atan(iter_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - chs_atan(iter_ff);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == LAST_IDX) begin
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            raw_in   = zero_ff ? '0 : z_round[CHS_ACC_W-1 -: ANGLE_BITS];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            prod_in  = PW'(d_wrap) * PW'($signed({1'b0, alpha_sat}));
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // The result waits here until the output register is free.
            if (!out_valid_ff || rsp_tready) begin
               emit = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         held_in       = new_held;
         first_in      = 1'b0;
         out_valid_in  = 1'b1;
         out_smooth_in = held_ext[CHS_OUT_W-1:0];
         out_raw_in    = raw_ext[CHS_OUT_W-1:0];
         state_in      = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff       <= iter_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      zero_ff       <= zero_in;
      raw_ff        <= raw_in;
      prod_ff       <= prod_in;
      out_smooth_ff <= out_smooth_in;
      out_raw_ff    <= out_raw_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_raw_ff, out_smooth_ff};

endmodule

@@ src/compass_heading_smoother_core.sv @@
// Magnetometer heading with wrap-aware exponential smoothing.
// Input stream req_*: one transaction carries a signed X and Y field sample.
// Output stream rsp_*: one transaction per input, carrying the smoothed and
// the raw heading as binary angles (a full turn is 2^ANGLE_BITS units).
// csr_wr_en/csr_wr_data write the 9-bit smoothing weight in 1/256 units;
// write it only while no transaction is in flight.
// A two-entry queue sits between the input classifier and the CORDIC engine,
// so samples are taken while the engine is busy or a result is stalled.
// The engine works on one sample at a time: the single shared CORDIC stage
// does one iteration per cycle, followed by rounding, difference and update
// steps, and the next sample is popped only after the result is emitted.
// A zero vector skips the iterations.
// Reset empties the queue and the output register, loads the weight 51
// and arms the first-sample load of the smoothed heading.
// While rsp_tready is low the result holds; the engine waits with the next
// result and the queue fills, after which req_tready falls.
module compass_heading_smoother_core
   import chs_pkg::*;
#(
   parameter int ANGLE_BITS   = CHS_ANGLE_BITS,
   parameter int CORDIC_STEPS = CHS_CORDIC_STEPS,
   parameter int QUEUE_DEPTH  = CHS_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // mag_x [15:0], mag_y [31:16]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // smoothed_heading [15:0], raw_heading [31:16]
   input  logic                   csr_wr_en,
   input  logic [CHS_ALPHA_W-1:0] csr_wr_data
);

   logic [CHS_ALPHA_W-1:0] alpha_ff, alpha_in;
   chs_qstat_type          q_status;
   chs_entry_type          push_entry;
   chs_entry_type          pop_entry;
   logic                   push;
   logic                   pop;

   assign alpha_in = csr_wr_en ? csr_wr_data : alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= CHS_ALPHA_RESET;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   chs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   chs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   chs_back #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_entry    (pop_entry),
      .pop        (pop),
      .alpha      (alpha_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ src/chs_checker.sv @@
`include "compass_heading_smoother_core_defines.svh"

module chs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result must stay offered and unchanged.
   `CHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed or dropped")

   // Nothing is left in the output register after a reset cycle.
   `CHS_ASSERT_NOW(a_rsp_cleared, clock, $past(reset), !rsp_tvalid, "result offered straight after reset")

   // The queue is empty after reset, so the input side must be ready.
   `CHS_ASSERT_NOW(a_req_open, clock, $past(reset), req_tready, "input not ready straight after reset")

endmodule

bind compass_heading_smoother_core chs_checker u_chs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
